// File: src/nmea_pkg.sv
// Package for the NMEA sentence receiver: widths, character codes, kinds and decode helpers.
// Used by every module in src; depends on nothing.
`default_nettype none
package nmea_pkg;
	localparam int LineDepth = 128;
	localparam int FillW = $clog2(LineDepth + 1);

	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChStar = 8'h2A;
	localparam logic [7:0] ChComma = 8'h2C;
	localparam logic [7:0] ChCr = 8'h0D;
	localparam logic [7:0] ChLf = 8'h0A;
	localparam logic [7:0] ChActive = 8'h41;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_GGA = 2'd1,
		KIND_RMC = 2'd2,
		KIND_GSA = 2'd3
	} kind_t;

	// Everything the line tracker hands to the finishing logic for one line.
	typedef struct packed {
		logic [FillW-1:0] fill;
		logic [7:0] xsum;
		logic star;
		logic [7:0] hex;
		logic [4:0] fidx;
		logic [47:0] head;
		logic [47:0] tchars;
		logic [47:0] dchars;
		logic time_full;
		logic date_full;
		logic q1;
		logic q2;
		logic s1;
		logic s2;
		logic [39:0] shorts;
	} line_t;

	typedef struct packed {
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] second;
		logic [7:0] fixq;
		logic [7:0] sats;
		logic [7:0] day;
		logic [7:0] month;
		logic [7:0] yr;
	} latch_t;

	function automatic logic [7:0] two_digit(input logic [7:0] a, input logic [7:0] b);
		logic [11:0] t;
		t = {4'd0, a} * 12'd10 + {4'd0, b} - 12'd528;
		return t[7:0];
	endfunction

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			r = {1'b0, c[3:0] + 4'd9};
		return r;
	endfunction

	function automatic logic [47:0] str6(input logic [7:0] a, b, c, d, e, f);
		return {f, e, d, c, b, a};
	endfunction
endpackage
`default_nettype wire

// File: src/nmea_line.sv
// Line tracker: header, checksum, hex suffix and field capture for the sentence in progress.
// Depends on nmea_pkg.
`default_nettype none
module nmea_line (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic take,
	input wire logic [7:0] c,
	output nmea_pkg::line_t line
);
	nmea_pkg::line_t cur_q, nxt;
	logic xstop_q, hexon_q, fon_q, xstop_n, hexon_n, fon_n;
	logic [5:0] flen_q, flen_n;
	logic [4:0] h;
	logic [2:0] q;

	assign line = cur_q;

	always_comb begin
		nxt = cur_q;
		xstop_n = xstop_q;
		hexon_n = hexon_q;
		fon_n = fon_q;
		flen_n = flen_q;
		h = nmea_pkg::hex_val(c);
		q = flen_q[2:0];
		if (c == nmea_pkg::ChDollar || (c != nmea_pkg::ChCr && c != nmea_pkg::ChLf
				&& cur_q.fill >= nmea_pkg::FillW'(nmea_pkg::LineDepth - 1))
				|| c == nmea_pkg::ChCr || c == nmea_pkg::ChLf) begin
			nxt = '0;
			xstop_n = 1'b0;
			hexon_n = 1'b0;
			fon_n = 1'b0;
			flen_n = '0;
		end
		// A '$' clears the line and is then taken as its first character.
		if (c != nmea_pkg::ChCr && c != nmea_pkg::ChLf && (c == nmea_pkg::ChDollar
				|| cur_q.fill < nmea_pkg::FillW'(nmea_pkg::LineDepth - 1))) begin
			if (nxt.fill < 6) nxt.head[8*nxt.fill[2:0] +: 8] = c;
			if (!xstop_n && nxt.fill != 0) begin
				if (c == nmea_pkg::ChStar) xstop_n = 1'b1;
				else nxt.xsum = nxt.xsum ^ c;
			end
			if (!nxt.star && c == nmea_pkg::ChStar) begin
				nxt.star = 1'b1;
				hexon_n = 1'b1;
			end else if (hexon_n) begin
				if (h[4]) hexon_n = 1'b0;
				else nxt.hex = {nxt.hex[3:0], h[3:0]};
			end
			if (c == nmea_pkg::ChComma) begin
				if (nxt.fidx != 5'd31) nxt.fidx = nxt.fidx + 5'd1;
				flen_n = '0;
				fon_n = 1'b1;
			end else if (c == nmea_pkg::ChStar) begin
				fon_n = 1'b0;
			end else if (fon_n) begin
				case (nxt.fidx)
					5'd1: begin
						if (flen_n < 6) nxt.tchars[8*q +: 8] = c;
						if (flen_n == 6'd5) nxt.time_full = 1'b1;
					end
					5'd2: if (flen_n == 0) nxt.shorts[7:0] = c;
					5'd6: begin
						if (flen_n == 0) begin nxt.shorts[15:8] = c; nxt.q1 = 1'b1; end
						if (flen_n == 1) begin nxt.shorts[23:16] = c; nxt.q2 = 1'b1; end
					end
					5'd7: begin
						if (flen_n == 0) begin nxt.shorts[31:24] = c; nxt.s1 = 1'b1; end
						if (flen_n == 1) begin nxt.shorts[39:32] = c; nxt.s2 = 1'b1; end
					end
					5'd9: begin
						if (flen_n < 6) nxt.dchars[8*q +: 8] = c;
						if (flen_n == 6'd5) nxt.date_full = 1'b1;
					end
					default: ;
				endcase
				if (flen_n != 6'd63) flen_n = flen_n + 6'd1;
			end
			nxt.fill = nxt.fill + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			xstop_q <= 1'b0;
			hexon_q <= 1'b0;
			fon_q <= 1'b0;
			flen_q <= '0;
		end else if (take) begin
			cur_q <= nxt;
			xstop_q <= xstop_n;
			hexon_q <= hexon_n;
			fon_q <= fon_n;
			flen_q <= flen_n;
		end
	end
endmodule
`default_nettype wire

// File: src/nmea_finish.sv
// End-of-line evaluation: checks length, checksum and header, updates latched time, fix and date.
// Depends on nmea_pkg.
`default_nettype none
module nmea_finish (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fin,
	input wire nmea_pkg::line_t line,
	output logic acc,
	output nmea_pkg::kind_t kind,
	output nmea_pkg::latch_t lat_n
);
	nmea_pkg::latch_t lat_q;
	logic good, gga, rmc, gsa;
	logic [7:0] c0, c1;

	assign good = line.fill >= 6 && line.star && line.xsum == line.hex;
	assign gga = line.head == nmea_pkg::str6("$","G","P","G","G","A")
		|| line.head == nmea_pkg::str6("$","G","N","G","G","A");
	assign rmc = line.head == nmea_pkg::str6("$","G","P","R","M","C")
		|| line.head == nmea_pkg::str6("$","G","N","R","M","C");
	assign gsa = line.head == nmea_pkg::str6("$","G","P","G","S","A")
		|| line.head == nmea_pkg::str6("$","G","N","G","S","A");

	always_comb begin
		lat_n = lat_q;
		acc = 1'b0;
		kind = nmea_pkg::KIND_OTHER;
		c0 = '0;
		c1 = '0;
		if (good && gga) begin
			kind = nmea_pkg::KIND_GGA;
			acc = 1'b1;
			if (line.fidx >= 1 && line.time_full) begin
				lat_n.hour = nmea_pkg::two_digit(line.tchars[7:0], line.tchars[15:8]);
				lat_n.minute = nmea_pkg::two_digit(line.tchars[23:16], line.tchars[31:24]);
				lat_n.second = nmea_pkg::two_digit(line.tchars[39:32], line.tchars[47:40]);
			end
			if (line.fidx >= 6) begin
				c0 = line.shorts[15:8];
				lat_n.fixq = !line.q1 ? 8'd0 : !line.q2 ? c0 - 8'd48
					: nmea_pkg::two_digit(c0, line.shorts[23:16]);
			end
			if (line.fidx >= 7) begin
				c1 = line.shorts[31:24];
				lat_n.sats = !line.s1 ? 8'd0 : !line.s2 ? c1 - 8'd48
					: nmea_pkg::two_digit(c1, line.shorts[39:32]);
			end
		end else if (good && rmc) begin
			kind = nmea_pkg::KIND_RMC;
			if (!(line.fidx >= 2 && line.shorts[7:0] != nmea_pkg::ChActive)) begin
				acc = 1'b1;
				if (line.fidx >= 9 && line.date_full) begin
					lat_n.day = nmea_pkg::two_digit(line.dchars[7:0], line.dchars[15:8]);
					lat_n.month = nmea_pkg::two_digit(line.dchars[23:16], line.dchars[31:24]);
					lat_n.yr = nmea_pkg::two_digit(line.dchars[39:32], line.dchars[47:40]);
				end
			end
		end else if (good && gsa) begin
			kind = nmea_pkg::KIND_GSA;
			acc = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lat_q <= '0;
		else if (fin) lat_q <= lat_n;
	end
endmodule
`default_nettype wire

// File: src/nmea_sentence_receiver.sv
// Top level of the NMEA sentence receiver: stream ports, line tracker, finisher, result register.
// Depends on nmea_pkg, nmea_line and nmea_finish.
//
// Channel | Direction | Carries
// s_axis  | in        | one received character per request
// m_axis  | out       | one result per CR or LF that ends a nonempty line
//
// One character is taken every cycle while no result is stalled; the line-state update and the
// end-of-line evaluation are combinational; a result appears in the cycle after its CR or LF.
// The result register holds a stalled result, and input stalls for as long as a result
// waits with m_axis_tready low. Reset clears the line and the latched values.
`default_nettype none
module nmea_sentence_receiver (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata, // [7:0] rx_byte
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// [0] accepted, [2:1] sentence_kind, [10:3] hour, [18:11] minute, [26:19] second,
	// [34:27] gps_quality, [35] fix_valid, [43:36] satellites, [51:44] day,
	// [59:52] month, [71:60] year
	output logic [71:0] m_axis_tdata
);
	nmea_pkg::line_t line;
	nmea_pkg::latch_t lat_n;
	nmea_pkg::kind_t kind;
	logic acc, take, eol, fin;

	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign take = s_axis_tvalid && s_axis_tready;
	assign eol = s_axis_tdata == nmea_pkg::ChCr || s_axis_tdata == nmea_pkg::ChLf;
	assign fin = take && eol && line.fill != 0;

	nmea_line u_line (.clk, .arst_n, .take, .c(s_axis_tdata), .line);
	nmea_finish u_fin (.clk, .arst_n, .fin, .line, .acc, .kind, .lat_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (fin) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin) m_axis_tdata <= {12'd2000 + {4'd0, lat_n.yr}, lat_n.month, lat_n.day,
			lat_n.sats, lat_n.fixq != 0, lat_n.fixq, lat_n.second, lat_n.minute,
			lat_n.hour, kind, acc};
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("input taken on stall");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> m_axis_tvalid) else $error("result lost");
	a_acc_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] != nmea_pkg::KIND_OTHER)
		else $error("accepted without kind");
endmodule
`default_nettype wire

// File: tb/sv/nmea_sentence_checker.sv
// Checker for the NMEA sentence receiver: watches both stream channels, predicts results.
// Depends on nmea_pkg for the kind codes and character constants.
module nmea_sentence_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [7:0] in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [71:0] out_data,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [11:0] year;
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] sats;
		logic fix_valid;
		logic [7:0] fixq;
		logic [7:0] second;
		logic [7:0] minute;
		logic [7:0] hour;
		nmea_pkg::kind_t kind;
		logic accepted;
	} report_t;

	localparam int DepthLimit = 128;

	int fill;
	logic [7:0] xsum, hexv;
	bit star, xor_stop, hex_on, field_on, q1, q2, s1, s2, tfull, dfull;
	int fidx, flen;
	logic [7:0] head [6];
	logic [7:0] tch [6];
	logic [7:0] dch [6];
	logic [7:0] status_ch, qc0, qc1, sc0, sc1;
	logic [7:0] l_hour, l_min, l_sec, l_fixq, l_sats, l_day, l_mon, l_yr;
	report_t expected_reports [$];

	function automatic logic [7:0] pair(input logic [7:0] a, input logic [7:0] b);
		return 8'(a * 10 + b - 528);
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 10;
		if (c >= "a" && c <= "f") return c - "a" + 10;
		return -1;
	endfunction

	function automatic bit header_is(input string s);
		for (int i = 0; i < 6; i++)
			if (head[i] != s[i]) return 0;
		return 1;
	endfunction

	function automatic logic [7:0] short_num(input logic [7:0] a, b, input bit l1, l2);
		if (!l1) return 0;
		if (!l2) return 8'(a - 48);
		return pair(a, b);
	endfunction

	task automatic clear_sentence();
		fill = 0; xsum = 0; hexv = 0; star = 0; xor_stop = 0; hex_on = 0;
		field_on = 0; q1 = 0; q2 = 0; s1 = 0; s2 = 0; tfull = 0; dfull = 0;
		fidx = 0; flen = 0; status_ch = 0; qc0 = 0; qc1 = 0; sc0 = 0; sc1 = 0;
		for (int i = 0; i < 6; i++) begin
			head[i] = 0; tch[i] = 0; dch[i] = 0;
		end
	endtask

	task automatic take_char(input logic [7:0] c);
		int h;
		if (fill < 6) head[fill] = c;
		if (!xor_stop && fill >= 1) begin
			if (c == nmea_pkg::ChStar) xor_stop = 1;
			else xsum ^= c;
		end
		if (!star && c == nmea_pkg::ChStar) begin
			star = 1;
			hex_on = 1;
		end else if (hex_on) begin
			h = hex_digit(c);
			if (h < 0) hex_on = 0;
			else hexv = {hexv[3:0], 4'(h)};
		end
		if (c == nmea_pkg::ChComma) begin
			if (fidx < 31) fidx++;
			flen = 0;
			field_on = 1;
		end else if (c == nmea_pkg::ChStar) begin
			field_on = 0;
		end else if (field_on) begin
			case (fidx)
				1: begin
					if (flen < 6) tch[flen] = c;
					if (flen == 5) tfull = 1;
				end
				2: if (flen == 0) status_ch = c;
				6: begin
					if (flen == 0) begin qc0 = c; q1 = 1; end
					if (flen == 1) begin qc1 = c; q2 = 1; end
				end
				7: begin
					if (flen == 0) begin sc0 = c; s1 = 1; end
					if (flen == 1) begin sc1 = c; s2 = 1; end
				end
				9: begin
					if (flen < 6) dch[flen] = c;
					if (flen == 5) dfull = 1;
				end
				default: ;
			endcase
			if (flen < 63) flen++;
		end
		fill++;
	endtask

	task automatic finish_sentence(output report_t r);
		logic acc;
		nmea_pkg::kind_t kind;
		acc = 0;
		kind = nmea_pkg::KIND_OTHER;
		if (fill >= 6 && star && xsum == hexv) begin
			if (header_is("$GPGGA") || header_is("$GNGGA")) begin
				kind = nmea_pkg::KIND_GGA;
				acc = 1;
				if (fidx >= 1 && tfull) begin
					l_hour = pair(tch[0], tch[1]);
					l_min = pair(tch[2], tch[3]);
					l_sec = pair(tch[4], tch[5]);
				end
				if (fidx >= 6) l_fixq = short_num(qc0, qc1, q1, q2);
				if (fidx >= 7) l_sats = short_num(sc0, sc1, s1, s2);
			end else if (header_is("$GPRMC") || header_is("$GNRMC")) begin
				kind = nmea_pkg::KIND_RMC;
				if (!(fidx >= 2 && status_ch != nmea_pkg::ChActive)) begin
					acc = 1;
					if (fidx >= 9 && dfull) begin
						l_day = pair(dch[0], dch[1]);
						l_mon = pair(dch[2], dch[3]);
						l_yr = pair(dch[4], dch[5]);
					end
				end
			end else if (header_is("$GPGSA") || header_is("$GNGSA")) begin
				kind = nmea_pkg::KIND_GSA;
				acc = 1;
			end
		end
		r.accepted = acc;
		r.kind = kind;
		r.hour = l_hour;
		r.minute = l_min;
		r.second = l_sec;
		r.fixq = l_fixq;
		r.fix_valid = l_fixq != 0;
		r.sats = l_sats;
		r.day = l_day;
		r.month = l_mon;
		r.year = 12'(2000 + l_yr);
	endtask

	task automatic predict_char(input logic [7:0] c);
		report_t r;
		if (c == nmea_pkg::ChDollar) begin
			clear_sentence();
			take_char(c);
		end else if (c == nmea_pkg::ChCr || c == nmea_pkg::ChLf) begin
			if (fill != 0) begin
				finish_sentence(r);
				clear_sentence();
				expected_reports.push_back(r);
			end
		end else if (fill < DepthLimit - 1) begin
			take_char(c);
		end else begin
			clear_sentence();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t want, got;
		if (!arst_n) begin
			clear_sentence();
			{l_hour, l_min, l_sec, l_fixq, l_sats, l_day, l_mon, l_yr} = '0;
			expected_reports.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = out_data;
				if (expected_reports.size() == 0) begin
					$display("%t: unexpected result %h", $realtime, out_data);
					errors <= errors + 1;
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						$display("%t: result mismatch: expected %h, actual %h", $realtime,
							want, got);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && in_ready) predict_char(in_data);
			pending <= expected_reports.size();
		end
	end
endmodule

// File: tb/sv/nmea_sentence_receiver_tb.sv
// Top of the NMEA sentence receiver testbench: clock, reset, character stimulus, verdict.
// Depends on nmea_pkg, the receiver RTL and nmea_sentence_checker.
module nmea_sentence_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 4000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [71:0] m_axis_tdata;
	int errors, pending;
	int idle_pct = 29;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	nmea_sentence_receiver uut (.*);

	nmea_sentence_checker checker_i (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
		.errors, .pending
	);

	always @(posedge clk)
		m_axis_tready <= $urandom_range(99) >= idle_pct;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > StallLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	// One request per character, with random gaps ahead of it.
	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= c;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	function automatic string hex2(input logic [7:0] v);
		return $sformatf("%02X", v);
	endfunction

	// Builds a sentence body, optionally with a correct checksum, and sends it.
	task automatic send_sentence(input string body, input bit good_sum, input bit lf);
		logic [7:0] x;
		x = 0;
		for (int i = 0; i < body.len(); i++) x ^= body[i];
		if (!good_sum) x ^= 8'(1 + $urandom_range(254));
		send_text({"$", body, "*", hex2(x)});
		send_char(lf ? nmea_pkg::ChLf : nmea_pkg::ChCr);
	endtask

	function automatic string digits(input int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
		return s;
	endfunction

	function automatic string field_text();
		string s;
		int n;
		s = "";
		n = $urandom_range(7);
		for (int i = 0; i < n; i++)
			case ($urandom_range(3))
				0: s = {s, string'(8'($urandom_range(32, 126)))};
				default: s = {s, string'(8'("0" + $urandom_range(9)))};
			endcase
		return s;
	endfunction

	function automatic string random_sentence();
		string talk, s;
		talk = $urandom_range(1) ? "GP" : "GN";
		case ($urandom_range(4))
			0: s = {talk, "GGA,", digits($urandom_range(4, 7)), ".00,4807.038,N,01131.000,E,",
				digits($urandom_range(0, 2)), ",", digits($urandom_range(0, 2)),
				",0.9,545.4,M,46.9,M,,"};
			1: s = {talk, "RMC,", digits(6), ",", ($urandom_range(3) != 0) ? "A" : "V",
				",4807.038,N,01131.000,E,022.4,084.4,", digits($urandom_range(4, 7)),
				",003.1,W"};
			2: s = {talk, "GSA,A,3,04,05,,09,12,,,,,,,,2.5,1.3,2.1"};
			3: s = {talk, "GGA"};
			default: begin
				s = {talk, ($urandom_range(1) ? "VTG" : "GGA")};
				repeat ($urandom_range(12)) s = {s, ",", field_text()};
			end
		endcase
		return s;
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed part.
		send_char(nmea_pkg::ChLf);
		send_sentence("GPGGA,235959.00,,,,,9,99,", 1, 0);
		send_sentence("GNGGA,000000,,,,,,,", 1, 1);
		send_sentence("GPRMC,1,A,,,,,,,311299,", 1, 0);
		send_sentence("GNRMC,1,V,,,,,,,010100,", 1, 1);
		send_sentence("GPRMC", 1, 0);
		send_sentence("GNGSA,A,3", 1, 0);
		send_sentence("GPGSA,A,3", 0, 0);
		send_text("$GPG*\n");
		send_text("*GPGGA*00\r");
		send_text("\xff\x80abc\n");
		send_sentence("GPGGA,zz9999,,,,,~,\x7f", 1, 0);
		repeat (130) send_char("A");
		send_char(nmea_pkg::ChCr);
		send_text("$GPGSA*4a\n");
		idle_pct = 0;
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// Random part, with one stretch of no idling.
		for (int n = 0; n < 22; n++) begin
			idle_pct = (n >= 6 && n < 11) ? 0 : 29;
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(1, 255)));
			send_sentence(random_sentence(), $urandom_range(5) != 0, $urandom_range(1));
		end
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
